// File: src/lkbc_pkg.sv
`default_nettype none
package lkbc_pkg;

   localparam int RegBitsDefault = 64;
   localparam int RegBitsMax     = 256;
   localparam int ByteBits       = 8;

   typedef enum logic {
      KIND_LOAD  = 1'b0,
      KIND_CRYPT = 1'b1
   } kind_type;

   function automatic logic [RegBitsMax-1:0] reset_pattern();
      logic [RegBitsMax-1:0] pat;
      pat = '0;
      for (int i = 0; i < RegBitsMax; i++) begin
         pat[i] = ((i % 4) == 0) || ((i % 5) == 0);
      end
      return pat;
   endfunction

endpackage
`default_nettype wire

// File: src/lkbc_step.sv
`default_nettype none
module lkbc_step
   import lkbc_pkg::*;
#(
   parameter int REG_BITS = RegBitsDefault
) (
   input  wire logic [REG_BITS-1:0] state,
   input  wire logic                kind,
   input  wire logic [ByteBits-1:0] data_byte,
   output logic      [REG_BITS-1:0] next_state,
   output logic      [ByteBits-1:0] out_byte
);

   logic [REG_BITS-1:0] work;
   logic [ByteBits-1:0] key;
   logic [ByteBits-1:0] data_rev;
   logic                fresh;

   always_comb begin
      work  = state;
      key   = '0;
      fresh = 1'b0;
      for (int k = 0; k < ByteBits; k++) begin
         fresh = work[0] ^ work[REG_BITS-1];
         work  = {work[REG_BITS-2:0], fresh};
         key   = {key[ByteBits-2:0], fresh};
      end
      for (int j = 0; j < ByteBits; j++) begin
         data_rev[j] = data_byte[ByteBits-1-j];
      end
      out_byte = data_byte ^ key;
      if (kind_type'(kind) == KIND_CRYPT) begin
         next_state = work;
      end else begin
         // enter at the back, MSB first
         next_state = {data_rev, state[REG_BITS-1:ByteBits]};
      end
   end

endmodule
`default_nettype wire

// File: src/lkbc_out_reg.sv
`default_nettype none
module lkbc_out_reg
   import lkbc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  wire logic [ByteBits-1:0] load_byte,
   output logic                     can_load,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic      [ByteBits-1:0] rsp_out_byte
);

   logic                valid_ff;
   logic                valid_in;
   logic [ByteBits-1:0] byte_ff;

   assign can_load     = !valid_ff || rsp_ready;
   assign valid_in     = load || (valid_ff && !rsp_ready);
   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= load_byte;
      end
   end

endmodule
`default_nettype wire

// File: src/lfsr_keystream_byte_cipher.sv
// Byte stream cipher over a REG_BITS-bit shift register. A load word
// (req_kind = 0) shifts req_data_byte in at the back, MSB first, and gives no
// response; a crypt word (req_kind = 1) runs eight register steps, each new
// front bit being front XOR back, and returns req_data_byte XOR those eight
// bits, first bit as MSB. One word (load or crypt) is taken per cycle unless a
// response is held unread: all eight steps are a single XOR network between the
// state and response registers, and the response register frees itself in the same cycle it is read.
`default_nettype none
module lfsr_keystream_byte_cipher
   import lkbc_pkg::*;
#(
   parameter int REG_BITS = RegBitsDefault
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                req_kind,
   input  wire logic [ByteBits-1:0] req_data_byte,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic      [ByteBits-1:0] rsp_out_byte
);

   localparam logic [RegBitsMax-1:0] ResetPattern = reset_pattern();

   logic [REG_BITS-1:0] state_ff;
   logic [REG_BITS-1:0] state_in;
   logic [ByteBits-1:0] step_byte;
   logic                take;
   logic                can_load;

   assign req_ready = can_load;
   assign take      = req_valid && can_load;

   lkbc_step #(
      .REG_BITS(REG_BITS)
   ) u_step (
      .state      (state_ff),
      .kind       (req_kind),
      .data_byte  (req_data_byte),
      .next_state (state_in),
      .out_byte   (step_byte)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ResetPattern[REG_BITS-1:0];
      end else if (take) begin
         state_ff <= state_in;
      end
   end

   lkbc_out_reg u_out (
      .clock        (clock),
      .reset        (reset),
      .load         (take && (kind_type'(req_kind) == KIND_CRYPT)),
      .load_byte    (step_byte),
      .can_load     (can_load),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte)
   );

endmodule
`default_nettype wire
